[hdl/dct_pkg.sv]
package dct_pkg;

	localparam int NUM_SLOTS_DEF = 8;
	localparam int WAIT_W = 20;
	localparam logic [WAIT_W-1:0] WAIT_RESET = 20'd16667;
	localparam logic [31:0] DUE_LIMIT = 32'd1;

	localparam logic REQ_REGISTER = 1'b0;
	localparam logic REQ_TICK = 1'b1;

	localparam logic [1:0] KIND_FIRED = 2'd0;
	localparam logic [1:0] KIND_SUMMARY = 2'd1;
	localparam logic [1:0] KIND_STORED = 2'd2;
	localparam logic [1:0] KIND_FULL = 2'd3;

	typedef struct packed {
		logic req_type;
		logic [31:0] now_us;
		logic [31:0] tag;
		logic [31:0] deadline_us;
	} req_t;

	typedef struct packed {
		logic [1:0] result_kind;
		logic [31:0] fired_tag;
		logic [2:0] slot_index;
		logic [WAIT_W-1:0] next_wait_us;
		logic last;
	} rsp_t;

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_SCAN,
		ST_DRAIN,
		ST_SUM
	} state_t;

	typedef struct packed {
		logic reg_go;
		logic tick_go;
		logic scan_rd;
		logic sum_go;
	} cmd_t;

	typedef struct packed {
		logic scan_last;
	} sts_t;

endpackage

[hdl/dct_ram.sv]
module dct_ram #(
	parameter int WIDTH = 64,
	parameter int DEPTH = 8
) (
	input  logic clk,
	input  logic we,
	input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] waddr,
	input  logic [WIDTH-1:0] wdata,
	input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] raddr,
	output logic [WIDTH-1:0] rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];
	logic [WIDTH-1:0] rdata_q;

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		rdata_q <= mem_q[raddr];
	end

	assign rdata = rdata_q;

endmodule

[hdl/dct_ctrl.sv]
module dct_ctrl (
	input  logic clk,
	input  logic arst_n,
	input  logic start,
	input  logic req_type,
	input  dct_pkg::sts_t sts,
	output dct_pkg::cmd_t cmd,
	output logic busy
);

	dct_pkg::state_t state_q;
	dct_pkg::state_t state_d;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= dct_pkg::ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		state_d = state_q;
		cmd = '0;
		busy = 1'b1;
		case (state_q)
			dct_pkg::ST_IDLE: begin
				busy = 1'b0;
				if (start) begin
					if (req_type == dct_pkg::REQ_TICK) begin
						cmd.tick_go = 1'b1;
						state_d = dct_pkg::ST_SCAN;
					end else begin
						cmd.reg_go = 1'b1;
					end
				end
			end
			dct_pkg::ST_SCAN: begin
				cmd.scan_rd = 1'b1;
				if (sts.scan_last) begin
					state_d = dct_pkg::ST_DRAIN;
				end
			end
			dct_pkg::ST_DRAIN: begin
				state_d = dct_pkg::ST_SUM;
			end
			dct_pkg::ST_SUM: begin
				cmd.sum_go = 1'b1;
				state_d = dct_pkg::ST_IDLE;
			end
			default: begin
				state_d = dct_pkg::ST_IDLE;
			end
		endcase
	end

endmodule

[hdl/dct_datapath.sv]
module dct_datapath #(
	parameter int NUM_SLOTS = dct_pkg::NUM_SLOTS_DEF
) (
	input  logic clk,
	input  logic arst_n,
	input  dct_pkg::cmd_t cmd,
	output dct_pkg::sts_t sts,
	input  dct_pkg::req_t req,
	input  logic wr_en,
	input  logic [dct_pkg::WAIT_W-1:0] wr_data,
	output dct_pkg::rsp_t rsp,
	output logic strobe
);

	localparam int IDX_W = (NUM_SLOTS > 1) ? $clog2(NUM_SLOTS) : 1;
	localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(NUM_SLOTS - 1);

	logic [NUM_SLOTS-1:0] valid_q;
	logic [dct_pkg::WAIT_W-1:0] max_wait_q;
	logic [dct_pkg::WAIT_W-1:0] min_q;
	logic [31:0] now_q;
	logic [IDX_W-1:0] idx_q;
	logic [IDX_W-1:0] idx_s1;
	logic chk_s1;
	logic strobe_q;
	dct_pkg::rsp_t rsp_q;
	dct_pkg::rsp_t rsp_d;

	logic free_found;
	logic [IDX_W-1:0] free_idx;
	logic [63:0] rd_data;
	logic [31:0] slot_tag;
	logic [31:0] diff;
	logic due;
	logic fire;
	logic keep;

	always_comb begin
		free_found = 1'b0;
		free_idx = '0;
		for (int i = NUM_SLOTS - 1; i >= 0; i--) begin
			if (!valid_q[i]) begin
				free_found = 1'b1;
				free_idx = IDX_W'(i);
			end
		end
	end

	dct_ram #(
		.WIDTH(64),
		.DEPTH(NUM_SLOTS)
	) u_slot_ram (
		.clk(clk),
		.we(cmd.reg_go && free_found),
		.waddr(free_idx),
		.wdata({req.tag, req.deadline_us}),
		.raddr(idx_q),
		.rdata(rd_data)
	);

	assign slot_tag = rd_data[63:32];
	assign diff = rd_data[31:0] - now_q;
	assign due = (diff <= dct_pkg::DUE_LIMIT) || diff[31];
	assign fire = chk_s1 && valid_q[idx_s1] && due;
	assign keep = chk_s1 && valid_q[idx_s1] && !due;
	assign sts.scan_last = (idx_q == LAST_IDX);

	always_comb begin
		rsp_d = '0;
		if (cmd.reg_go) begin
			rsp_d.last = 1'b1;
			if (free_found) begin
				rsp_d.result_kind = dct_pkg::KIND_STORED;
				rsp_d.slot_index = 3'(free_idx);
			end else begin
				rsp_d.result_kind = dct_pkg::KIND_FULL;
			end
		end else if (fire) begin
			rsp_d.result_kind = dct_pkg::KIND_FIRED;
			rsp_d.fired_tag = slot_tag;
			rsp_d.slot_index = 3'(idx_s1);
		end else if (cmd.sum_go) begin
			rsp_d.result_kind = dct_pkg::KIND_SUMMARY;
			rsp_d.next_wait_us = min_q;
			rsp_d.last = 1'b1;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= '0;
			max_wait_q <= dct_pkg::WAIT_RESET;
			chk_s1 <= 1'b0;
			strobe_q <= 1'b0;
		end else begin
			if (wr_en) begin
				max_wait_q <= wr_data;
			end
			if (cmd.reg_go && free_found) begin
				valid_q[free_idx] <= 1'b1;
			end
			if (fire) begin
				valid_q[idx_s1] <= 1'b0;
			end
			chk_s1 <= cmd.scan_rd;
			strobe_q <= cmd.reg_go || fire || cmd.sum_go;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.tick_go) begin
			idx_q <= '0;
			now_q <= req.now_us;
			min_q <= max_wait_q;
		end else if (cmd.scan_rd) begin
			idx_q <= idx_q + 1'b1;
		end
		idx_s1 <= idx_q;
		if (keep && (diff < {12'd0, min_q})) begin
			min_q <= diff[dct_pkg::WAIT_W-1:0];
		end
		rsp_q <= rsp_d;
	end

	assign rsp = rsp_q;
	assign strobe = strobe_q;

`ifndef SYNTHESIS
	a_sum_after_drain: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.sum_go |-> !chk_s1)
		else $error("Summary issued while a slot evaluation is pending.");

	a_reg_not_in_scan: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.reg_go |-> !chk_s1 && !cmd.scan_rd)
		else $error("Register request overlaps a tick scan.");

	a_fire_clears: assert property (@(posedge clk) disable iff (!arst_n)
		fire |=> !valid_q[$past(idx_s1)])
		else $error("Fired slot is still marked valid.");

	a_store_sets: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.reg_go && free_found |=> valid_q[$past(free_idx)])
		else $error("Stored slot is not marked valid.");
`endif

endmodule

[hdl/deadline_callback_table_top.sv]
// Register request: busy stays low, and the stored or table-full result is registered and appears
// in the cycle after start is accepted.
// Tick request: busy through the scan, drain and summary states; the scan reads one slot per cycle.
// Fired results follow one per due slot, and the summary comes after them with last set.
// Results carry no back-pressure; each is valid for one cycle while strobe is high.
// Reset clears all slots and loads the default maximum wait; no clearing pass is needed.
module deadline_callback_table_top #(
	parameter int NUM_SLOTS = dct_pkg::NUM_SLOTS_DEF
) (
	input  logic clk,
	input  logic arst_n,
	input  logic start,
	output logic busy,
	input  dct_pkg::req_t req,
	output dct_pkg::rsp_t rsp,
	output logic strobe,
	input  logic wr_en,
	input  logic [dct_pkg::WAIT_W-1:0] wr_data
);

	dct_pkg::cmd_t cmd;
	dct_pkg::sts_t sts;

	dct_ctrl u_ctrl (
		.clk(clk),
		.arst_n(arst_n),
		.start(start),
		.req_type(req.req_type),
		.sts(sts),
		.cmd(cmd),
		.busy(busy)
	);

	dct_datapath #(
		.NUM_SLOTS(NUM_SLOTS)
	) u_datapath (
		.clk(clk),
		.arst_n(arst_n),
		.cmd(cmd),
		.sts(sts),
		.req(req),
		.wr_en(wr_en),
		.wr_data(wr_data),
		.rsp(rsp),
		.strobe(strobe)
	);

endmodule
